[rtl/core/psu_pkg.sv]
package psu_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] REG_SAMPLE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
	localparam logic [1:0] REG_TWO_BIT_HIGH  = 2'd2;
	localparam logic [1:0] REG_FOUR_BIT_STEP = 2'd3;

	localparam logic [1:0] WIDTH_1 = 2'd0;
	localparam logic [1:0] WIDTH_2 = 2'd1;
	localparam logic [1:0] WIDTH_4 = 2'd2;
	localparam logic [1:0] WIDTH_8 = 2'd3;

	localparam logic [1:0]  RESET_SAMPLE_WIDTH  = WIDTH_2;
	localparam logic [2:0]  RESET_CHANNEL_COUNT = 3'd0;
	localparam logic [14:0] RESET_TWO_BIT_HIGH  = 15'd13664;
	localparam logic [11:0] RESET_FOUR_BIT_STEP = 12'd1388;

	localparam logic signed [15:0] LEVEL_ONE = 16'sd4096;

	typedef struct packed {
		logic [7:0] payload;
		logic       blanked;
		logic [1:0] width_code;
		logic [3:0] chan_start;
		logic [3:0] chan_mask;
	} entry_t;

	function automatic logic [2:0] last_index(input logic [1:0] width_code);
		logic [2:0] idx;
		case (width_code)
			WIDTH_1: idx = 3'd7;
			WIDTH_2: idx = 3'd3;
			WIDTH_4: idx = 3'd1;
			default: idx = 3'd0;
		endcase
		return idx;
	endfunction

endpackage

[rtl/core/psu_front.sv]
module psu_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           payload_byte,
	input  logic                 byte_blanked,
	input  logic [1:0]           width_code,
	input  logic [2:0]           chan_code,
	output psu_pkg::entry_t      entry
);

	logic [3:0] next_chan_q;
	logic [3:0] chan_mask;
	logic [3:0] chan_start;
	logic [3:0] sample_count;

	always_comb begin
		case (chan_code)
			3'd0:    chan_mask = 4'h0;
			3'd1:    chan_mask = 4'h1;
			3'd2:    chan_mask = 4'h3;
			3'd3:    chan_mask = 4'h7;
			default: chan_mask = 4'hF;
		endcase
	end

	assign chan_start   = next_chan_q & chan_mask;
	assign sample_count = {1'b0, psu_pkg::last_index(width_code)} + 4'd1;

	assign entry.payload    = payload_byte;
	assign entry.blanked    = byte_blanked;
	assign entry.width_code = width_code;
	assign entry.chan_start = chan_start;
	assign entry.chan_mask  = chan_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_chan_q <= 4'd0;
		end else if (accept) begin
			next_chan_q <= (chan_start + sample_count) & chan_mask;
		end
	end

endmodule

[rtl/core/psu_queue.sv]
module psu_queue #(
	parameter int DEPTH = psu_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  psu_pkg::entry_t wr_data,
	output logic            full,
	input  logic            rd_en,
	output psu_pkg::entry_t rd_data,
	output logic            rd_valid
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	psu_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full     = (count_q == FULL_COUNT);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_COUNT)
		else $error("Queue count exceeds its depth.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && full && !rd_en) |=> (count_q == FULL_COUNT))
		else $error("Queue took an item while full.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_rd && !do_wr) |=> (count_q == $past(count_q) - 1'b1))
		else $error("Queue count did not drop on a read.");

endmodule

[rtl/core/psu_back.sv]
module psu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  psu_pkg::entry_t     head,
	input  logic                head_valid,
	output logic                head_pop,
	input  logic [14:0]         two_bit_high_level,
	input  logic [11:0]         four_bit_step,
	input  logic                pop,
	output logic                empty,
	output logic [3:0]          channel_index,
	output logic signed [15:0]  sample_level,
	output logic                sample_valid,
	output logic                last_of_byte
);

	logic [2:0]         k_q;
	logic               out_valid_q;
	logic [3:0]         chan_q;
	logic signed [15:0] level_q;
	logic               valid_q;
	logic               last_q;

	logic               advance;
	logic [2:0]         last_k;
	logic               is_last;
	logic [2:0]         shift;
	logic [7:0]         code;
	logic signed [15:0] high_level;
	logic signed [16:0] four_bit_prod;
	logic signed [15:0] level;

	assign advance = head_valid && (!out_valid_q || pop);
	assign last_k  = psu_pkg::last_index(head.width_code);
	assign is_last = (k_q == last_k);
	assign head_pop = advance && is_last;
	assign shift   = k_q << head.width_code;
	assign code    = head.payload >> shift;

	assign high_level    = $signed({1'b0, two_bit_high_level});
	assign four_bit_prod = $signed({~code[3], code[2:0]}) * $signed({1'b0, four_bit_step});

	always_comb begin
		case (head.width_code)
			psu_pkg::WIDTH_1: begin
				level = code[0] ? psu_pkg::LEVEL_ONE : -psu_pkg::LEVEL_ONE;
			end
			psu_pkg::WIDTH_2: begin
				case (code[1:0])
					2'd0:    level = -high_level;
					2'd1:    level = psu_pkg::LEVEL_ONE;
					2'd2:    level = -psu_pkg::LEVEL_ONE;
					default: level = high_level;
				endcase
			end
			psu_pkg::WIDTH_4: begin
				level = four_bit_prod[15:0];
			end
			default: begin
				level = {{4{~code[7]}}, code[6:0], 1'b1, 4'b0000};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				k_q <= is_last ? 3'd0 : k_q + 3'd1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			chan_q  <= (head.chan_start + {1'b0, k_q}) & head.chan_mask;
			level_q <= head.blanked ? 16'sd0 : level;
			valid_q <= !head.blanked;
			last_q  <= is_last;
		end
	end

	assign empty         = !out_valid_q;
	assign channel_index = chan_q;
	assign sample_level  = level_q;
	assign sample_valid  = valid_q;
	assign last_of_byte  = last_q;

	assert property (@(posedge clk) disable iff (!arst_n) !head_valid |-> (k_q == 3'd0))
		else $error("Sample counter left nonzero with no byte pending.");
	assert property (@(posedge clk) disable iff (!arst_n) head_valid |-> (k_q <= last_k))
		else $error("Sample counter ran past the last sample of the byte.");
	assert property (@(posedge clk) disable iff (!arst_n) head_pop |=> last_q)
		else $error("Byte retired without its last sample marked.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !valid_q) |-> (level_q == 16'sd0))
		else $error("Blanked sample carries a nonzero level.");

endmodule

[rtl/core/packed_sample_unpacker.sv]
// Unpacks one payload byte per item into 8, 4, 2 or 1 samples (1, 2, 4 or 8 bits each,
// lowest bits first), maps each to a signed Q3.12 level and deals them round-robin to
// the configured channels. The sample serializer in the back end emits one sample per
// cycle while pop keeps its output register free, and a short queue lets bytes be taken
// while it works. Blanked bytes still yield their full sample count with level zero and
// sample_valid low. The user must write registers through the APB port only while the
// block is idle; the block itself does not enforce this.
module packed_sample_unpacker #(
	parameter int QUEUE_DEPTH = psu_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         payload_byte,
	input  logic               byte_blanked,
	input  logic               pop,
	output logic               empty,
	output logic [3:0]         channel_index,
	output logic signed [15:0] sample_level,
	output logic               sample_valid,
	output logic               last_of_byte
);

	logic [1:0]  width_code_q;
	logic [2:0]  chan_code_q;
	logic [14:0] two_bit_high_q;
	logic [11:0] four_bit_step_q;

	logic [1:0]      reg_index;
	logic            cfg_write;
	logic            accept;
	psu_pkg::entry_t front_entry;
	psu_pkg::entry_t head;
	logic            head_valid;
	logic            head_pop;

	assign pready    = 1'b1;
	assign reg_index = paddr[3:2];
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_code_q    <= psu_pkg::RESET_SAMPLE_WIDTH;
			chan_code_q     <= psu_pkg::RESET_CHANNEL_COUNT;
			two_bit_high_q  <= psu_pkg::RESET_TWO_BIT_HIGH;
			four_bit_step_q <= psu_pkg::RESET_FOUR_BIT_STEP;
		end else if (cfg_write) begin
			case (reg_index)
				psu_pkg::REG_SAMPLE_WIDTH:  width_code_q    <= pwdata[1:0];
				psu_pkg::REG_CHANNEL_COUNT: chan_code_q     <= pwdata[2:0];
				psu_pkg::REG_TWO_BIT_HIGH:  two_bit_high_q  <= pwdata[14:0];
				psu_pkg::REG_FOUR_BIT_STEP: four_bit_step_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			psu_pkg::REG_SAMPLE_WIDTH:  prdata = {30'd0, width_code_q};
			psu_pkg::REG_CHANNEL_COUNT: prdata = {29'd0, chan_code_q};
			psu_pkg::REG_TWO_BIT_HIGH:  prdata = {17'd0, two_bit_high_q};
			psu_pkg::REG_FOUR_BIT_STEP: prdata = {20'd0, four_bit_step_q};
			default:                    prdata = 32'd0;
		endcase
	end

	assign accept = push && !full;

	psu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.payload_byte (payload_byte),
		.byte_blanked (byte_blanked),
		.width_code   (width_code_q),
		.chan_code    (chan_code_q),
		.entry        (front_entry)
	);

	psu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_data  (front_entry),
		.full     (full),
		.rd_en    (head_pop),
		.rd_data  (head),
		.rd_valid (head_valid)
	);

	psu_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.head               (head),
		.head_valid         (head_valid),
		.head_pop           (head_pop),
		.two_bit_high_level (two_bit_high_q),
		.four_bit_step      (four_bit_step_q),
		.pop                (pop),
		.empty              (empty),
		.channel_index      (channel_index),
		.sample_level       (sample_level),
		.sample_valid       (sample_valid),
		.last_of_byte       (last_of_byte)
	);

endmodule
